// ----- hw/rtl/tone_and_led_indication_sequencer_defines.svh -----
// assertion macros for the tone and led indication sequencer
// no dependencies; included by the top level only
`ifndef TONE_AND_LED_INDICATION_SEQUENCER_DEFINES_SVH
`define TONE_AND_LED_INDICATION_SEQUENCER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TLIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlis assertion failed");

// antecedent implies consequent in the next cycle
`define TLIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlis assertion failed");

`endif

// ----- hw/rtl/tlis_pkg.sv -----
// shared types, constants and the note table of the tone and led sequencer
// no dependencies
package tlis_pkg;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 28;
	localparam logic [CFG_IDX_W-1:0] CFG_SYS_CLOCK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'd1;
	localparam logic [27:0] SYS_CLOCK_RESET = 28'd125000000;
	localparam logic [6:0] VOLUME_RESET = 7'd100;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_LED = 2'd2;

	localparam logic [2:0] TUNE_OFF = 3'd0;
	localparam logic [2:0] TUNE_POWERUP = 3'd1;
	localparam logic [2:0] TUNE_CHG_START = 3'd2;
	localparam logic [2:0] TUNE_CHG_STOP = 3'd3;
	localparam logic [2:0] TUNE_SLEEP = 3'd4;
	localparam logic [2:0] TUNE_WAKE = 3'd5;

	localparam logic LED_IDLE = 1'b0;
	localparam logic LED_CHARGING = 1'b1;

	// shared divider: dividend width, remainder and divisor width
	localparam int DIV_W = 28;
	localparam int DIVR_W = 12;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [DIVR_W-1:0] HZ_C5 = DIVR_W'(52325 / 100);
	localparam logic [DIVR_W-1:0] HZ_E5 = DIVR_W'(65925 / 100);
	localparam logic [DIVR_W-1:0] HZ_G5 = DIVR_W'(78399 / 100);
	localparam logic [DIVR_W-1:0] HZ_C6 = DIVR_W'(104650 / 100);
	localparam logic [DIVR_W-1:0] HZ_C7 = DIVR_W'(209300 / 100);
	localparam logic [DIVR_W-1:0] HZ_G6 = DIVR_W'(156798 / 100);
	localparam logic [DIVR_W-1:0] LEVEL_DIVISOR = DIVR_W'(100);

	// one tenth with 11 fractional bits
	localparam logic [7:0] RECIP10 = 8'd205;

	localparam logic [7:0] GREEN_ON = 8'd200;
	localparam logic [6:0] RAMP_MIN = 7'd10;
	localparam logic [6:0] RAMP_MAX = 7'd100;
	localparam logic [6:0] RAMP_STEP = 7'd2;

	// elapsed ticks are saturated to this width before the table lookup
	localparam int ELAPSED_W = 6;

	typedef enum logic [1:0] {
		NOTE_TONE,
		NOTE_REST,
		NOTE_END
	} note_kind_t;

	typedef struct packed {
		note_kind_t kind;
		logic [DIVR_W-1:0] hz;
	} note_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] tick_number;
		logic [2:0] seq_select;
	} cmd_t;

	typedef struct packed {
		logic tone_on;
		logic [15:0] tone_wrap;
		logic [15:0] tone_level;
		logic [2:0] buzzer_sequence;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic [7:0] white_level;
	} status_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic step;
		logic tick_div10;
		logic pat_we;
		logic pat_sel;
	} led_ctl_t;

	function automatic note_t make_note(input note_kind_t kind, input logic [DIVR_W-1:0] hz);
		note_t n;
		n.kind = kind;
		n.hz = hz;
		return n;
	endfunction

	function automatic note_t pick_note(input logic [2:0] tune, input logic [ELAPSED_W-1:0] t);
		note_t n;
		n = make_note(NOTE_REST, '0);
		case (tune)
			TUNE_POWERUP: begin
				if (t < 6'd8) n = make_note(NOTE_TONE, HZ_C5);
				else if (t < 6'd16) n = make_note(NOTE_TONE, HZ_E5);
				else if (t < 6'd24) n = make_note(NOTE_TONE, HZ_G5);
				else if (t < 6'd32) n = make_note(NOTE_TONE, HZ_C6);
				else n = make_note(NOTE_END, '0);
			end
			TUNE_CHG_START: begin
				if (t < 6'd5) n = make_note(NOTE_TONE, HZ_C7);
				else if (t < 6'd10) n = make_note(NOTE_REST, '0);
				else if (t < 6'd15) n = make_note(NOTE_TONE, HZ_C7);
				else n = make_note(NOTE_END, '0);
			end
			TUNE_CHG_STOP: begin
				if (t < 6'd5) n = make_note(NOTE_TONE, HZ_G6);
				else n = make_note(NOTE_END, '0);
			end
			TUNE_SLEEP: begin
				if (t < 6'd10) n = make_note(NOTE_TONE, HZ_G5);
				else if (t < 6'd20) n = make_note(NOTE_TONE, HZ_E5);
				else if (t < 6'd30) n = make_note(NOTE_TONE, HZ_C5);
				else n = make_note(NOTE_END, '0);
			end
			TUNE_WAKE: begin
				if (t < 6'd10) n = make_note(NOTE_TONE, HZ_C5);
				else if (t < 6'd20) n = make_note(NOTE_TONE, HZ_E5);
				else if (t < 6'd30) n = make_note(NOTE_TONE, HZ_G5);
				else n = make_note(NOTE_END, '0);
			end
			default: n = make_note(NOTE_REST, '0);
		endcase
		return n;
	endfunction

endpackage

// ----- hw/rtl/tlis_chan_if.sv -----
// valid/ready channel carrying one payload beat
// payload type is set per instance; no other dependencies
interface tlis_chan_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tone_and_led_indication_sequencer.sv -----
// Tone and LED indication sequencer. Takes one command beat at a time (tick, start of a buzzer
// sequence, LED pattern choice) and returns one status beat showing the state after it. A tick
// that sounds a note goes through the shared 28-bit divider twice, once for the PWM wrap
// (clock / note frequency, then / 8) and once for the level (wrap * volume / 100, then / 2).
// A tick with a rest or the end of a sequence goes from the lookup straight to done and skips
// the divider, as do other commands. The command side is not ready while a beat is in work; a
// finished status beat waits in an output register, so the next command may be taken meanwhile.
// depends on tlis_pkg, tlis_chan_if, tlis_div, tlis_led and the assertion macro header
module tone_and_led_indication_sequencer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tlis_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlis_pkg::CFG_DATA_W-1:0] cfg_data,
	tlis_chan_if.sink cmd_chan,
	tlis_chan_if.source status_chan
);
	import tlis_pkg::*;
	`include "tone_and_led_indication_sequencer_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_WRAP,
		ST_MUL,
		ST_LEVEL,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [27:0] sys_clock_q;
	logic [6:0] volume_q;
	logic [2:0] tune_q;
	logic pending_q;
	logic [31:0] start_q;
	logic [31:0] tick_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [9:0] mod_sum_q;
	logic [15:0] wrap_q;
	logic [15:0] level_q;
	logic tone_en_q;
	logic out_valid_q;
	status_t status_q;

	cmd_t cmd_in;
	logic accept;
	logic [31:0] start_eff;
	logic [31:0] elapsed;
	logic [6:0] nib_hi;
	logic [9:0] nib_sum;
	logic [17:0] div10_prod;
	logic [6:0] div10_q;
	logic tick_div10;
	note_t note;
	logic slot_free;
	logic [7:0] green;
	logic [7:0] blue;
	div_req_t div_req;
	div_rsp_t div_rsp;
	led_ctl_t led_ctl;

	assign cmd_in = cmd_chan.payload;
	assign cmd_chan.ready = (state_q == ST_IDLE);
	assign accept = cmd_chan.valid && cmd_chan.ready;
	assign slot_free = !out_valid_q || status_chan.ready;

	// elapsed ticks, saturated so the note table sees a narrow value
	assign start_eff = pending_q ? cmd_in.tick_number : start_q;
	assign elapsed = cmd_in.tick_number - start_eff;

	// 16^k mod 10 is 6 for k >= 1, so the nibble sum keeps the remainder mod 10
	always_comb begin
		nib_hi = 7'(cmd_in.tick_number[7:4]) + 7'(cmd_in.tick_number[11:8])
			+ 7'(cmd_in.tick_number[15:12]) + 7'(cmd_in.tick_number[19:16])
			+ 7'(cmd_in.tick_number[23:20]) + 7'(cmd_in.tick_number[27:24])
			+ 7'(cmd_in.tick_number[31:28]);
		nib_sum = 10'(nib_hi) * 10'd6 + 10'(cmd_in.tick_number[3:0]);
	end

	// reciprocal multiply, exact for the nibble sum range
	assign div10_prod = 18'(mod_sum_q) * 18'(RECIP10);
	assign div10_q = div10_prod[17:11];
	assign tick_div10 = (10'(div10_q) * 10'd10) == mod_sum_q;

	assign note = pick_note(tune_q, elapsed_q);

	always_comb begin
		div_req = '0;
		if (state_q == ST_LOOKUP && note.kind == NOTE_TONE) begin
			div_req.start = 1'b1;
			div_req.dividend = sys_clock_q;
			div_req.divisor = note.hz;
		end else if (state_q == ST_MUL) begin
			div_req.start = 1'b1;
			div_req.dividend = DIV_W'(wrap_q) * DIV_W'(volume_q);
			div_req.divisor = LEVEL_DIVISOR;
		end
	end

	always_comb begin
		led_ctl.step = (state_q == ST_LOOKUP);
		led_ctl.tick_div10 = tick_div10;
		led_ctl.pat_we = accept && cmd_in.cmd == CMD_LED
			&& cmd_in.seq_select <= 3'(LED_CHARGING);
		led_ctl.pat_sel = cmd_in.seq_select[0];
	end

	tlis_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	tlis_led u_led (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(led_ctl),
		.green(green),
		.blue(blue)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sys_clock_q <= SYS_CLOCK_RESET;
			volume_q <= VOLUME_RESET;
			tune_q <= TUNE_POWERUP;
			pending_q <= 1'b0;
			start_q <= '0;
			tick_q <= '0;
			elapsed_q <= '0;
			mod_sum_q <= '0;
			wrap_q <= '0;
			level_q <= '0;
			tone_en_q <= 1'b0;
			out_valid_q <= 1'b0;
			status_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYS_CLOCK: sys_clock_q <= cfg_data;
					CFG_VOLUME: volume_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (status_chan.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_in.cmd)
							CMD_TICK: begin
								state_q <= ST_LOOKUP;
								tick_q <= cmd_in.tick_number;
								mod_sum_q <= nib_sum;
								elapsed_q <= (elapsed[31:ELAPSED_W] != '0)
									? '1 : elapsed[ELAPSED_W-1:0];
								if (pending_q) begin
									pending_q <= 1'b0;
									start_q <= cmd_in.tick_number;
								end
							end
							CMD_START: begin
								state_q <= ST_DONE;
								if (cmd_in.seq_select <= TUNE_WAKE) begin
									tune_q <= cmd_in.seq_select;
									pending_q <= 1'b1;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_LOOKUP: begin
					case (note.kind)
						NOTE_TONE: state_q <= ST_WRAP;
						NOTE_END: begin
							tune_q <= TUNE_OFF;
							start_q <= tick_q;
							tone_en_q <= 1'b0;
							state_q <= ST_DONE;
						end
						default: begin
							tone_en_q <= 1'b0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WRAP: begin
					if (div_rsp.done) begin
						wrap_q <= div_rsp.quotient[18:3];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_LEVEL;
				ST_LEVEL: begin
					if (div_rsp.done) begin
						level_q <= div_rsp.quotient[16:1];
						tone_en_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						status_q.tone_on <= tone_en_q;
						status_q.tone_wrap <= wrap_q;
						status_q.tone_level <= level_q;
						status_q.buzzer_sequence <= tune_q;
						status_q.red_level <= '0;
						status_q.green_level <= green;
						status_q.blue_level <= blue;
						status_q.white_level <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign status_chan.valid = out_valid_q;
	assign status_chan.payload = status_q;

	`TLIS_ASSERT_SAME(a_div_done_expected, clk, arst_n, div_rsp.done,
		state_q == ST_WRAP || state_q == ST_LEVEL)
	`TLIS_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`TLIS_ASSERT_SAME(a_tune_in_range, clk, arst_n, out_valid_q,
		status_q.buzzer_sequence <= TUNE_WAKE && tune_q <= TUNE_WAKE)
endmodule

// ----- hw/rtl/tlis_div.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on tlis_pkg
module tlis_div (
	input logic clk,
	input logic arst_n,
	input tlis_pkg::div_req_t req,
	output tlis_pkg::div_rsp_t rsp
);
	import tlis_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] num_q;
	logic [DIVR_W-1:0] den_q;
	logic [DIVR_W-1:0] rem_q;

	logic [DIVR_W:0] trial;
	logic fits;
	logic [DIVR_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		fits = trial >= {1'b0, den_q};
		rem_next = fits ? DIVR_W'(trial - {1'b0, den_q}) : trial[DIVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = num_q;
endmodule

// ----- hw/rtl/tlis_led.sv -----
// led pattern state: idle green toggle and charging blue ramp
// depends on tlis_pkg
module tlis_led (
	input logic clk,
	input logic arst_n,
	input tlis_pkg::led_ctl_t ctl,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import tlis_pkg::*;

	logic pattern_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [6:0] ramp_q;
	logic rising_q;

	logic [6:0] ramp_up;
	logic [6:0] ramp_down;

	assign ramp_up = ramp_q + RAMP_STEP;
	assign ramp_down = ramp_q - RAMP_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= LED_IDLE;
			green_q <= '0;
			blue_q <= '0;
			ramp_q <= RAMP_MIN;
			rising_q <= 1'b1;
		end else begin
			if (ctl.pat_we) begin
				pattern_q <= ctl.pat_sel;
			end
			if (ctl.step) begin
				if (pattern_q == LED_IDLE) begin
					if (ctl.tick_div10) begin
						green_q <= (green_q == 8'd0) ? GREEN_ON : 8'd0;
					end
					blue_q <= '0;
				end else begin
					green_q <= '0;
					if (rising_q) begin
						if (ramp_up >= RAMP_MAX) begin
							rising_q <= 1'b0;
							ramp_q <= RAMP_MAX;
							blue_q <= 8'(RAMP_MAX);
						end else begin
							ramp_q <= ramp_up;
							blue_q <= 8'(ramp_up);
						end
					end else begin
						if (ramp_down <= RAMP_MIN) begin
							rising_q <= 1'b1;
							ramp_q <= RAMP_MIN;
							blue_q <= 8'(RAMP_MIN);
						end else begin
							ramp_q <= ramp_down;
							blue_q <= 8'(ramp_down);
						end
					end
				end
			end
		end
	end

	assign green = green_q;
	assign blue = blue_q;
endmodule

// ----- tb/tlis_status_checker.sv -----
// predicts the status beat for every accepted command beat and compares it with the block's output
// depends on tlis_pkg; instantiated by tb_tone_and_led_indication_sequencer
module tlis_status_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [tlis_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlis_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic cmd_valid,
	input logic cmd_ready,
	input tlis_pkg::cmd_t cmd_beat,
	input logic status_valid,
	input logic status_ready,
	input tlis_pkg::status_t status_beat,
	output int mismatches,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import tlis_pkg::*;

	// note frequencies in whole hertz
	localparam logic [DIVR_W-1:0] C5_HZ = DIVR_W'(52325 / 100);
	localparam logic [DIVR_W-1:0] E5_HZ = DIVR_W'(65925 / 100);
	localparam logic [DIVR_W-1:0] G5_HZ = DIVR_W'(78399 / 100);
	localparam logic [DIVR_W-1:0] C6_HZ = DIVR_W'(104650 / 100);
	localparam logic [DIVR_W-1:0] C7_HZ = DIVR_W'(209300 / 100);
	localparam logic [DIVR_W-1:0] G6_HZ = DIVR_W'(156798 / 100);
	localparam logic [7:0] GREEN_LIT = 8'd200;
	localparam logic [6:0] BREATH_LOW = 7'd10;
	localparam logic [6:0] BREATH_HIGH = 7'd100;
	localparam logic [6:0] BREATH_STEP = 7'd2;

	logic [27:0] clock_hz;
	logic [6:0] volume;
	logic [2:0] active_tune;
	bit restart_pending;
	logic [31:0] tune_start;
	logic led_pattern;
	logic [7:0] green;
	logic [7:0] blue;
	logic [6:0] ramp;
	bit ramp_rising;
	logic [15:0] wrap;
	logic [15:0] level;
	bit tone_en;
	status_t status_due[$];

	function automatic note_t tune_note(input logic [2:0] tune, input logic [31:0] elapsed);
		note_t n;
		n.kind = NOTE_TONE;
		n.hz = '0;
		case (tune)
			TUNE_POWERUP: begin
				if (elapsed < 8) n.hz = C5_HZ;
				else if (elapsed < 16) n.hz = E5_HZ;
				else if (elapsed < 24) n.hz = G5_HZ;
				else if (elapsed < 32) n.hz = C6_HZ;
				else n.kind = NOTE_END;
			end
			TUNE_CHG_START: begin
				if (elapsed < 5) n.hz = C7_HZ;
				else if (elapsed < 10) n.kind = NOTE_REST;
				else if (elapsed < 15) n.hz = C7_HZ;
				else n.kind = NOTE_END;
			end
			TUNE_CHG_STOP: begin
				if (elapsed < 5) n.hz = G6_HZ;
				else n.kind = NOTE_END;
			end
			TUNE_SLEEP: begin
				if (elapsed < 10) n.hz = G5_HZ;
				else if (elapsed < 20) n.hz = E5_HZ;
				else if (elapsed < 30) n.hz = C5_HZ;
				else n.kind = NOTE_END;
			end
			TUNE_WAKE: begin
				if (elapsed < 10) n.hz = C5_HZ;
				else if (elapsed < 20) n.hz = E5_HZ;
				else if (elapsed < 30) n.hz = G5_HZ;
				else n.kind = NOTE_END;
			end
			default: n.kind = NOTE_REST;
		endcase
		return n;
	endfunction

	task automatic advance_sequencer(input cmd_t beat, output status_t next);
		note_t n;
		case (beat.cmd)
			CMD_TICK: begin
				// first tick after a start fixes the time origin of the tune
				if (restart_pending) begin
					restart_pending = 1'b0;
					tune_start = beat.tick_number;
				end
				n = tune_note(active_tune, beat.tick_number - tune_start);
				case (n.kind)
					NOTE_END: begin
						active_tune = TUNE_OFF;
						tune_start = beat.tick_number;
						tone_en = 1'b0;
					end
					NOTE_REST: tone_en = 1'b0;
					default: begin
						wrap = 16'((clock_hz / 28'(n.hz)) / 28'd8);
						level = 16'(((32'(wrap) * 32'(volume)) / 32'd100) / 32'd2);
						tone_en = 1'b1;
					end
				endcase
				if (led_pattern == LED_IDLE) begin
					if (beat.tick_number % 32'd10 == 32'd0)
						green = (green == 8'd0) ? GREEN_LIT : 8'd0;
					blue = 8'd0;
				end else begin
					if (ramp_rising) begin
						ramp = ramp + BREATH_STEP;
						if (ramp >= BREATH_HIGH) begin
							ramp_rising = 1'b0;
							ramp = BREATH_HIGH;
						end
					end else begin
						ramp = ramp - BREATH_STEP;
						if (ramp <= BREATH_LOW) begin
							ramp_rising = 1'b1;
							ramp = BREATH_LOW;
						end
					end
					blue = {1'b0, ramp};
					green = 8'd0;
				end
			end
			CMD_START: begin
				if (beat.seq_select <= TUNE_WAKE) begin
					active_tune = beat.seq_select;
					restart_pending = 1'b1;
				end
			end
			CMD_LED: begin
				if (beat.seq_select <= 3'(LED_CHARGING))
					led_pattern = beat.seq_select[0];
			end
			default: ;
		endcase
		next.tone_on = tone_en;
		next.tone_wrap = wrap;
		next.tone_level = level;
		next.buzzer_sequence = active_tune;
		next.red_level = 8'd0;
		next.green_level = green;
		next.blue_level = blue;
		next.white_level = 8'd0;
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		status_t next;
		if (!arst_n) begin
			clock_hz = SYS_CLOCK_RESET;
			volume = VOLUME_RESET;
			active_tune = TUNE_POWERUP;
			restart_pending = 1'b0;
			tune_start = '0;
			led_pattern = LED_IDLE;
			green = '0;
			blue = '0;
			ramp = BREATH_LOW;
			ramp_rising = 1'b1;
			wrap = '0;
			level = '0;
			tone_en = 1'b0;
			status_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYS_CLOCK: clock_hz = cfg_data;
					CFG_VOLUME: volume = cfg_data[6:0];
					default: ;
				endcase
			end
			// a status beat can never belong to a command taken at the same edge
			if (status_valid && status_ready) begin
				if (status_due.size() == 0) begin
					$display("%0t: status beat with nothing expected, actual %h", $time,
						status_beat);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					check_field("tone_on", want.tone_on, status_beat.tone_on);
					check_field("tone_wrap", want.tone_wrap, status_beat.tone_wrap);
					check_field("tone_level", want.tone_level, status_beat.tone_level);
					check_field("buzzer_sequence", want.buzzer_sequence,
						status_beat.buzzer_sequence);
					check_field("red_level", want.red_level, status_beat.red_level);
					check_field("green_level", want.green_level, status_beat.green_level);
					check_field("blue_level", want.blue_level, status_beat.blue_level);
					check_field("white_level", want.white_level, status_beat.white_level);
				end
			end
			if (cmd_valid && cmd_ready) begin
				advance_sequencer(cmd_beat, next);
				status_due.push_back(next);
			end
			outstanding = status_due.size();
		end
	end

endmodule

// ----- tb/tb_tone_and_led_indication_sequencer.sv -----
// top of the sequencer testbench: clock, reset, command and config stimulus, verdict
// depends on tlis_pkg, tlis_chan_if, tlis_status_checker and the block itself
module tb_tone_and_led_indication_sequencer;
	timeunit 1ns;
	timeprecision 1ps;
	import tlis_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int mismatches;
	int outstanding;
	int idle_pct;
	logic [31:0] tick_count;

	tlis_chan_if #(.payload_t(cmd_t)) cmd_chan ();
	tlis_chan_if #(.payload_t(status_t)) status_chan ();

	tone_and_led_indication_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_chan(cmd_chan),
		.status_chan(status_chan)
	);

	tlis_status_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_chan.valid),
		.cmd_ready(cmd_chan.ready),
		.cmd_beat(cmd_chan.payload),
		.status_valid(status_chan.valid),
		.status_ready(status_chan.ready),
		.status_beat(status_chan.payload),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// status side: stalls in bursts whenever idling is on
	initial begin
		int stall_left;
		stall_left = 0;
		status_chan.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && idle_pct > 0 && $urandom_range(99) < idle_pct)
				stall_left = $urandom_range(17, 1);
			status_chan.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	function automatic cmd_t beat_of(input logic [1:0] cmd, input logic [31:0] tick,
		input logic [2:0] sel);
		cmd_t b;
		b.cmd = cmd;
		b.tick_number = tick;
		b.seq_select = sel;
		return b;
	endfunction

	// mostly running ticks with the odd start or pattern change, plus some noise
	function automatic cmd_t random_beat();
		cmd_t b;
		int pick;
		pick = $urandom_range(999);
		b = beat_of(CMD_TICK, $urandom, 3'($urandom_range(7)));
		if (pick < 850) begin
			if (pick < 15) tick_count = $urandom;
			else if (pick < 25) tick_count = 32'hFFFF_FFF0 + $urandom_range(15);
			else tick_count = tick_count + 32'd1;
			b.tick_number = tick_count;
		end else if (pick < 900) begin
			b.cmd = CMD_START;
			b.seq_select = (pick < 890) ? 3'($urandom_range(TUNE_WAKE, TUNE_OFF))
				: 3'($urandom_range(7, 6));
		end else if (pick < 960) begin
			b.cmd = CMD_LED;
			if (pick < 950) b.seq_select = {2'b00, 1'($urandom_range(1))};
		end else if (pick < 985) begin
			b.cmd = CMD_UNUSED;
		end
		return b;
	endfunction

	task automatic send_beat(input cmd_t beat);
		int gap;
		gap = (idle_pct > 0 && $urandom_range(99) < idle_pct) ? $urandom_range(17, 1) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_chan.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_chan.valid <= 1'b1;
		cmd_chan.payload <= beat;
		do @(posedge clk); while (!cmd_chan.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		cmd_chan.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		// the block is already idle again once the last status beat has been taken
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [27:0] clock_hz, input logic [6:0] volume,
		input int count, input int pct);
		cmd_t b;
		int sent;
		drain();
		write_reg(CFG_SYS_CLOCK, clock_hz);
		write_reg(CFG_VOLUME, CFG_DATA_W'(volume));
		idle_pct = pct;
		sent = 0;
		while (sent < count) begin
			b = random_beat();
			send_beat(b);
			if (!(b.cmd == CMD_UNUSED || (b.cmd == CMD_START && b.seq_select > TUNE_WAKE)
				|| (b.cmd == CMD_LED && b.seq_select > 3'(LED_CHARGING))))
				sent++;
			// now and then hold off until every status beat is back
			if ($urandom_range(149) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_chan.valid = 1'b0;
		cmd_chan.payload = '0;
		idle_pct = 0;
		tick_count = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// powerup tune from reset: first note, last note, then the end
		idle_pct = 8;
		send_beat(beat_of(CMD_TICK, 32'd0, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'd31, 3'd7));
		send_beat(beat_of(CMD_TICK, 32'd32, 3'd0));
		send_beat(beat_of(CMD_UNUSED, 32'hFFFF_FFFF, 3'd7));
		send_beat(beat_of(CMD_START, 32'hA5A5_5A5A, 3'd6));
		send_beat(beat_of(CMD_START, 32'h0, 3'd7));
		send_beat(beat_of(CMD_LED, 32'h0, 3'd2));
		send_beat(beat_of(CMD_LED, 32'hFFFF_FFFF, 3'd7));
		send_beat(beat_of(CMD_LED, 32'h0, {2'b00, LED_CHARGING}));
		// charging start across the wrap of the tick count: tone, rest, tone, end
		send_beat(beat_of(CMD_START, 32'h0, TUNE_CHG_START));
		send_beat(beat_of(CMD_TICK, 32'hFFFF_FFFE, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'h0000_0004, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'h0000_0009, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'h0000_0010, 3'd0));
		send_beat(beat_of(CMD_START, 32'h0, TUNE_CHG_STOP));
		send_beat(beat_of(CMD_TICK, 32'd100, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'd105, 3'd0));
		send_beat(beat_of(CMD_START, 32'h0, TUNE_SLEEP));
		send_beat(beat_of(CMD_TICK, 32'd7, 3'd0));
		send_beat(beat_of(CMD_START, 32'h0, TUNE_WAKE));
		send_beat(beat_of(CMD_TICK, 32'd8, 3'd0));
		// a start of off relatches and then only rests
		send_beat(beat_of(CMD_START, 32'h0, TUNE_OFF));
		send_beat(beat_of(CMD_LED, 32'h0, {2'b00, LED_IDLE}));
		send_beat(beat_of(CMD_TICK, 32'd10, 3'd0));
		send_beat(beat_of(CMD_TICK, 32'd20, 3'd0));

		run_phase(28'd1_000_000, 7'd0, 220, 10);
		run_phase(28'd250_000_000, 7'd100, 220, 25);
		run_phase(28'hFFF_FFFF, 7'd127, 200, 5);
		// zero clock gives zero wrap and level
		run_phase(28'd0, 7'd50, 120, 10);
		run_phase(28'($urandom_range(250_000_000, 1_000_000)), 7'($urandom_range(100)), 220, 0);
		run_phase(28'($urandom), 7'($urandom_range(127)), 220, 15);
		run_phase(SYS_CLOCK_RESET, VOLUME_RESET, 200, 30);
		run_phase(28'($urandom_range(250_000_000, 1_000_000)), 7'($urandom_range(100)), 400, 0);

		drain();
		repeat (70) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
